### hw/rtl/spet_pkg.sv
// Shared constants and types of the snapshot press-edge tracker.
package spet_pkg;

   localparam int NUM_SOURCES_DEF = 3;
   localparam int NUM_BUTTONS_DEF = 16;
   localparam int MAX_BUTTONS     = 16;
   localparam int COUNT_W         = 16;
   localparam int TIME_W          = 32;
   localparam int SRC_ID_W        = 2;
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd250000;

   // Tracker decision for the transaction being presented.
   typedef struct packed {
      logic upd;    // available, in range and in order
      logic clear;  // stream changed or tracker not live
      logic fresh;  // upd, valid, stamped and within timeout
   } trk_ctl_type;

   typedef struct packed {
      logic                   accepted;
      logic                   fresh;
      logic [MAX_BUTTONS-1:0] pressed_mask;
      logic [MAX_BUTTONS-1:0] held_out;
      logic [TIME_W-1:0]      stamp_out;
   } rsp_payload_type;

endpackage

### hw/rtl/spet_req_if.sv
// Request and response channel interfaces of the snapshot press-edge tracker.
interface spet_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  source_id;
   logic        available;
   logic [31:0] stream_gen;
   logic [31:0] seq_num;
   logic [31:0] stamp_us;
   logic [31:0] now_time_us;
   logic        snap_valid;
   logic [15:0] held_in;
   logic [63:0] counts_a;
   logic [63:0] counts_b;
   logic [63:0] counts_c;
   logic [63:0] counts_d;

   modport source (output valid, source_id, available, stream_gen, seq_num, stamp_us,
                   now_time_us, snap_valid, held_in, counts_a, counts_b, counts_c,
                   counts_d, input ready);
   modport sink   (input valid, source_id, available, stream_gen, seq_num, stamp_us,
                   now_time_us, snap_valid, held_in, counts_a, counts_b, counts_c,
                   counts_d, output ready);
endinterface

interface spet_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        fresh;
   logic [15:0] pressed_mask;
   logic [15:0] held_out;
   logic [31:0] stamp_out;

   modport source (output valid, accepted, fresh, pressed_mask, held_out, stamp_out,
                   input ready);
   modport sink   (input valid, accepted, fresh, pressed_mask, held_out, stamp_out,
                   output ready);
endinterface

### hw/rtl/snapshot_press_edge_tracker.sv
// Top level of the snapshot press-edge tracker.
//
// Usage:
//  - req_chan carries one controller snapshot per transaction (valid/ready);
//    source_id picks one of NUM_SOURCES trackers, ids at or above it are
//    ignored and give an all-zero result.
//  - rsp_chan returns exactly one result transaction per request, in order.
//  - csr_wr_en/csr_wr_data write timeout_us; write only while idle.
//  - The result is registered and valid in the cycle after the request is taken.
//  - Throughput: one transaction per cycle while rsp_chan is not stalled.
//    The tracker decision and the up to sixteen button lanes are combinational,
//    and the update is written at the edge that takes the request, so the next
//    snapshot of the same source may follow in the next cycle.
//  - A single output register parts the channels: req_chan.ready is high
//    when that register is empty or is being drained this cycle.
//  - When the receiver stalls, the result holds and the request side stalls
//    with it after one transaction.
//  - Reset (synchronous, active high) marks all trackers not live, empties
//    the output register and sets timeout_us to 250000.
module snapshot_press_edge_tracker #(
   parameter int NUM_SOURCES = spet_pkg::NUM_SOURCES_DEF,
   parameter int NUM_BUTTONS = spet_pkg::NUM_BUTTONS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   spet_req_if.sink                    req_chan,
   spet_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [spet_pkg::TIME_W-1:0] csr_wr_data
);

   localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   logic [spet_pkg::TIME_W-1:0]          timeout_ff;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   spet_pkg::rsp_payload_type            rsp_data_ff;
   spet_pkg::rsp_payload_type            rsp_data_in;

   logic                                 fire;
   logic [SRC_W-1:0]                     idx;
   spet_pkg::trk_ctl_type                ctl;
   logic [4*64-1:0]                      counts;
   logic [spet_pkg::MAX_BUTTONS-1:0]     pressed;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;
   // button 4k+j sits in bits 16j..16j+15 of word k
   assign counts = {req_chan.counts_d, req_chan.counts_c,
                    req_chan.counts_b, req_chan.counts_a};

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= spet_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   spet_track #(
      .NUM_SOURCES (NUM_SOURCES),
      .SRC_W       (SRC_W)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .source_id   (req_chan.source_id),
      .available   (req_chan.available),
      .stream_gen  (req_chan.stream_gen),
      .seq_num     (req_chan.seq_num),
      .stamp_us    (req_chan.stamp_us),
      .now_time_us (req_chan.now_time_us),
      .snap_valid  (req_chan.snap_valid),
      .timeout_us  (timeout_ff),
      .idx         (idx),
      .ctl         (ctl)
   );

   // one lane per button; unused button positions never report a press
   for (genvar b = 0; b < spet_pkg::MAX_BUTTONS; b++) begin : g_lane
      if (b < NUM_BUTTONS) begin : g_on
         spet_lane #(
            .NUM_SOURCES (NUM_SOURCES),
            .SRC_W       (SRC_W)
         ) u_lane (
            .clock    (clock),
            .idx      (idx),
            .ctl      (ctl),
            .wr_en    (fire && ctl.upd),
            .count_in (counts[b*spet_pkg::COUNT_W +: spet_pkg::COUNT_W]),
            .pressed  (pressed[b])
         );
      end else begin : g_off
         assign pressed[b] = 1'b0;
      end
   end

   // merge the lane results with the tracker decision
   always_comb begin
      rsp_data_in.accepted     = ctl.upd;
      rsp_data_in.fresh        = ctl.fresh;
      rsp_data_in.pressed_mask = ctl.fresh ? pressed : '0;
      rsp_data_in.held_out     = ctl.fresh ? req_chan.held_in : '0;
      rsp_data_in.stamp_out    = ctl.upd ? req_chan.stamp_us : '0;
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.accepted     = rsp_data_ff.accepted;
   assign rsp_chan.fresh        = rsp_data_ff.fresh;
   assign rsp_chan.pressed_mask = rsp_data_ff.pressed_mask;
   assign rsp_chan.held_out     = rsp_data_ff.held_out;
   assign rsp_chan.stamp_out    = rsp_data_ff.stamp_out;

endmodule

### hw/rtl/spet_lane.sv
// One button lane: stored counters of every source and the change compare.
module spet_lane #(
   parameter int NUM_SOURCES = spet_pkg::NUM_SOURCES_DEF,
   parameter int SRC_W       = 2
) (
   input  logic                        clock,
   input  logic [SRC_W-1:0]            idx,
   input  spet_pkg::trk_ctl_type       ctl,
   input  logic                        wr_en,
   input  logic [spet_pkg::COUNT_W-1:0] count_in,
   output logic                        pressed
);

   logic [spet_pkg::COUNT_W-1:0] count_ff [NUM_SOURCES];
   logic [spet_pkg::COUNT_W-1:0] prev;

   // a cleared tracker compares against zero
   assign prev    = ctl.clear ? '0 : count_ff[idx];
   assign pressed = (count_in != prev);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_ff[idx] <= count_in;
      end
   end

endmodule

### hw/rtl/spet_track.sv
// Per-source stream, sequence and live state; ordering and freshness decision.
module spet_track #(
   parameter int NUM_SOURCES = spet_pkg::NUM_SOURCES_DEF,
   parameter int SRC_W       = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [spet_pkg::SRC_ID_W-1:0]   source_id,
   input  logic                            available,
   input  logic [spet_pkg::TIME_W-1:0]     stream_gen,
   input  logic [spet_pkg::TIME_W-1:0]     seq_num,
   input  logic [spet_pkg::TIME_W-1:0]     stamp_us,
   input  logic [spet_pkg::TIME_W-1:0]     now_time_us,
   input  logic                            snap_valid,
   input  logic [spet_pkg::TIME_W-1:0]     timeout_us,
   output logic [SRC_W-1:0]                idx,
   output spet_pkg::trk_ctl_type           ctl
);

   logic                          live_ff   [NUM_SOURCES];
   logic [spet_pkg::TIME_W-1:0]   stream_ff [NUM_SOURCES];
   logic [spet_pkg::TIME_W-1:0]   seq_ff    [NUM_SOURCES];

   logic                          src_ok;
   logic                          ordered;
   logic [spet_pkg::TIME_W-1:0]   seq_diff;
   logic [spet_pkg::TIME_W-1:0]   age;

   assign idx      = SRC_W'(source_id);
   assign src_ok   = available && (int'(source_id) < NUM_SOURCES);
   assign ctl.clear = !live_ff[idx] || (stream_ff[idx] != stream_gen);
   // wrapping order: not older when the difference has a clear sign bit
   assign seq_diff = seq_num - seq_ff[idx];
   assign ordered  = ctl.clear || !snap_valid || !seq_diff[spet_pkg::TIME_W-1];
   assign ctl.upd  = src_ok && ordered;
   assign age      = now_time_us - stamp_us;
   assign ctl.fresh = ctl.upd && snap_valid && (stamp_us != '0) && (age <= timeout_us);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SOURCES; s++) begin
            live_ff[s] <= 1'b0;
         end
      end else if (fire && ctl.upd) begin
         live_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && ctl.upd) begin
         stream_ff[idx] <= stream_gen;
         seq_ff[idx]    <= seq_num;
      end
   end

endmodule

### hw/rtl/spet_checker.sv
// Port-level checks of the snapshot press-edge tracker and their bind.
module spet_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_available,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic        rsp_fresh,
   input logic [15:0] rsp_pressed_mask,
   input logic [15:0] rsp_held_out,
   input logic [31:0] rsp_stamp_out
);

   // a stalled result stays presented
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // every taken transaction shows its result in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("result missing one cycle after request");

   // back-pressure only comes from a full, stalled output register
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a stalled result");

   // an unavailable snapshot gives an all-zero result
   a_unavail: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_available |=>
         !rsp_accepted && !rsp_fresh && rsp_stamp_out == '0)
      else $error("unavailable snapshot produced a result");

   // buttons are only reported by a fresh, accepted result
   a_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fresh |-> rsp_pressed_mask == '0 && rsp_held_out == '0)
      else $error("buttons reported on a stale result");

endmodule

bind snapshot_press_edge_tracker spet_checker u_spet_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_available    (req_chan.available),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_accepted     (rsp_chan.accepted),
   .rsp_fresh        (rsp_chan.fresh),
   .rsp_pressed_mask (rsp_chan.pressed_mask),
   .rsp_held_out     (rsp_chan.held_out),
   .rsp_stamp_out    (rsp_chan.stamp_out)
);
